/* design/ooksw_pkg.sv */
// ----------------------------------------------------------------------------
// ooksw_pkg: shared types and constants of the OOK remote-switch encoder
// Frame layout, segment phases, register indexes and payload structs.
// ----------------------------------------------------------------------------
package ooksw_pkg;

  localparam int unsigned SENDER_BITS = 26;
  localparam int unsigned UNIT_BITS   = 4;
  localparam int unsigned FRAME_BITS  = SENDER_BITS + 2 + UNIT_BITS;
  localparam int unsigned POS_W       = 5;
  localparam int unsigned TIME_W      = 16;
  localparam int unsigned REP_W       = 8;
  localparam int unsigned CFG_IDX_W   = 3;

  localparam logic [TIME_W-1:0] HIGH_TIME_RST  = 16'd275;
  localparam logic [TIME_W-1:0] ZERO_LOW_RST   = 16'd275;
  localparam logic [TIME_W-1:0] ONE_LOW_RST    = 16'd1225;
  localparam logic [TIME_W-1:0] START_LOW_RST  = 16'd2675;
  localparam logic [TIME_W-1:0] END_LOW_RST    = 16'd10000;
  localparam logic [REP_W-1:0]  REPEAT_RST     = 8'd10;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_HIGH_TIME      = 3'd0,
    REG_ZERO_LOW_TIME  = 3'd1,
    REG_ONE_LOW_TIME   = 3'd2,
    REG_START_LOW_TIME = 3'd3,
    REG_END_LOW_TIME   = 3'd4,
    REG_REPEAT_COUNT   = 3'd5
  } reg_idx_e;

  typedef enum logic [2:0] {
    PH_IDLE       = 3'd0,
    PH_START_HIGH = 3'd1,
    PH_START_LOW  = 3'd2,
    PH_BIT_HIGH   = 3'd3,
    PH_BIT_LOW    = 3'd4,
    PH_END_HIGH   = 3'd5,
    PH_END_LOW    = 3'd6
  } phase_e;

  localparam logic CMD_TICK = 1'b0;
  localparam logic CMD_SEND = 1'b1;

  typedef struct packed {
    logic        command;
    logic [25:0] sender_code;
    logic [3:0]  unit_code;
    logic        switch_on;
  } in_item_t;

  typedef struct packed {
    logic line_level;
    logic busy_res;
  } out_item_t;

  typedef struct packed {
    logic [TIME_W-1:0] high_time;
    logic [TIME_W-1:0] zero_low_time;
    logic [TIME_W-1:0] one_low_time;
    logic [TIME_W-1:0] start_low_time;
    logic [TIME_W-1:0] end_low_time;
    logic [REP_W-1:0]  repeat_count;
  } cfg_t;

  // A programmed duration of zero still lasts one tick.
  function automatic logic [TIME_W-1:0] seg_len(input logic [TIME_W-1:0] v);
    seg_len = (v == '0) ? TIME_W'(1) : v;
  endfunction

endpackage

/* design/ook_remote_switch_frame_encoder.sv */
// ----------------------------------------------------------------------------
// ook_remote_switch_frame_encoder: 433 MHz remote-switch OOK frame encoder
// Tick and send items drive a start latch, 32 bit pairs and an end latch.
// ----------------------------------------------------------------------------
//   Channel   Direction  Handshake                 Payload
//   in        input      in_valid_i / in_ready_o   ooksw_pkg::in_item_t
//   out       output     out_valid_o / out_ready_i ooksw_pkg::out_item_t
//   cfg       input      cfg_valid_i / cfg_ready_o cfg_index_i, cfg_data_i
//
// One item is taken per cycle while in_ready_o is high; its result is
// registered in the output buffer. A two-entry output buffer lets one more
// item in while a result waits, and in_ready_o drops only when both entries
// are full. The configuration port is always ready. Reset clears the
// sequencer to idle and loads the default timing values.
// ----------------------------------------------------------------------------
module ook_remote_switch_frame_encoder (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  ooksw_pkg::in_item_t         in_data_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output ooksw_pkg::out_item_t        out_data_o,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [ooksw_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [ooksw_pkg::TIME_W-1:0]    cfg_data_i
);

  ooksw_pkg::cfg_t      cfg_q;
  ooksw_pkg::out_item_t result;
  logic                 space;
  logic                 in_accept;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = space;
  assign in_accept   = in_valid_i && space;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.high_time      <= ooksw_pkg::HIGH_TIME_RST;
      cfg_q.zero_low_time  <= ooksw_pkg::ZERO_LOW_RST;
      cfg_q.one_low_time   <= ooksw_pkg::ONE_LOW_RST;
      cfg_q.start_low_time <= ooksw_pkg::START_LOW_RST;
      cfg_q.end_low_time   <= ooksw_pkg::END_LOW_RST;
      cfg_q.repeat_count   <= ooksw_pkg::REPEAT_RST;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        ooksw_pkg::REG_HIGH_TIME:      cfg_q.high_time      <= cfg_data_i;
        ooksw_pkg::REG_ZERO_LOW_TIME:  cfg_q.zero_low_time  <= cfg_data_i;
        ooksw_pkg::REG_ONE_LOW_TIME:   cfg_q.one_low_time   <= cfg_data_i;
        ooksw_pkg::REG_START_LOW_TIME: cfg_q.start_low_time <= cfg_data_i;
        ooksw_pkg::REG_END_LOW_TIME:   cfg_q.end_low_time   <= cfg_data_i;
        ooksw_pkg::REG_REPEAT_COUNT:
          cfg_q.repeat_count <= cfg_data_i[ooksw_pkg::REP_W-1:0];
        default: ;
      endcase
    end
  end

  ooksw_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (in_accept),
    .item_i   (in_data_i),
    .cfg_i    (cfg_q),
    .result_o (result)
  );

  ooksw_skid u_skid (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (in_accept),
    .push_data_i (result),
    .space_o     (space),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

/* design/ooksw_core.sv */
// ----------------------------------------------------------------------------
// ooksw_core: segment sequencer of the OOK encoder
// Updates the frame timing state for each accepted item and forms its result.
// ----------------------------------------------------------------------------
module ooksw_core (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                accept_i,
  input  ooksw_pkg::in_item_t item_i,
  input  ooksw_pkg::cfg_t     cfg_i,
  output ooksw_pkg::out_item_t result_o
);

  logic [ooksw_pkg::FRAME_BITS-1:0] frame_q, frame_d;
  logic [ooksw_pkg::POS_W-1:0]      pos_q, pos_d;
  logic                             half_q, half_d;
  ooksw_pkg::phase_e                phase_q, phase_d;
  logic [ooksw_pkg::TIME_W-1:0]     ticks_q, ticks_d;
  logic [ooksw_pkg::REP_W-1:0]      reps_q, reps_d;
  logic                             line_q, line_d;

  logic                             busy;
  logic [ooksw_pkg::TIME_W-1:0]     ticks_dec;
  logic [ooksw_pkg::REP_W-1:0]      reps_dec;
  logic [ooksw_pkg::POS_W:0]        shamt;
  logic                             frame_bit;
  logic                             half_val;
  logic                             last_bit;

  assign busy      = (phase_q != ooksw_pkg::PH_IDLE);
  assign ticks_dec = ticks_q - ooksw_pkg::TIME_W'(1);
  assign reps_dec  = reps_q - ooksw_pkg::REP_W'(1);

  // Bit being sent, most significant first, XOR the half of the pair.
  assign shamt     = (ooksw_pkg::POS_W + 1)'(ooksw_pkg::FRAME_BITS - 1) - {1'b0, pos_q};
  assign frame_bit = ({1'b0, pos_q} < (ooksw_pkg::POS_W + 1)'(ooksw_pkg::FRAME_BITS))
                     ? frame_q[shamt[ooksw_pkg::POS_W-1:0]] : 1'b0;
  assign half_val  = frame_bit ^ half_q;
  assign last_bit  = ({1'b0, pos_q} >= (ooksw_pkg::POS_W + 1)'(ooksw_pkg::FRAME_BITS - 1));

  always_comb begin
    frame_d  = frame_q;
    pos_d    = pos_q;
    half_d   = half_q;
    phase_d  = phase_q;
    ticks_d  = ticks_q;
    reps_d   = reps_q;
    line_d   = line_q;
    result_o = '0;

    if (item_i.command == ooksw_pkg::CMD_SEND) begin
      if (!busy && (cfg_i.repeat_count != '0)) begin
        frame_d = {item_i.sender_code[ooksw_pkg::SENDER_BITS-1:0], 1'b0,
                   item_i.switch_on, item_i.unit_code[ooksw_pkg::UNIT_BITS-1:0]};
        pos_d   = '0;
        half_d  = 1'b0;
        reps_d  = cfg_i.repeat_count;
        phase_d = ooksw_pkg::PH_START_HIGH;
        ticks_d = ooksw_pkg::seg_len(cfg_i.high_time);
        line_d  = 1'b1;
      end
      result_o.line_level = line_d;
      result_o.busy_res   = (phase_d != ooksw_pkg::PH_IDLE);
    end else if (!busy) begin
      line_d = 1'b0;
    end else begin
      result_o.line_level = line_q;
      result_o.busy_res   = 1'b1;
      ticks_d = ticks_dec;
      if (ticks_dec == '0) begin
        case (phase_q)
          ooksw_pkg::PH_START_HIGH: begin
            phase_d = ooksw_pkg::PH_START_LOW;
            ticks_d = ooksw_pkg::seg_len(cfg_i.start_low_time);
            line_d  = 1'b0;
          end
          ooksw_pkg::PH_START_LOW: begin
            pos_d   = '0;
            half_d  = 1'b0;
            phase_d = ooksw_pkg::PH_BIT_HIGH;
            ticks_d = ooksw_pkg::seg_len(cfg_i.high_time);
            line_d  = 1'b1;
          end
          ooksw_pkg::PH_BIT_HIGH: begin
            phase_d = ooksw_pkg::PH_BIT_LOW;
            ticks_d = ooksw_pkg::seg_len(half_val ? cfg_i.one_low_time
                                                  : cfg_i.zero_low_time);
            line_d  = 1'b0;
          end
          ooksw_pkg::PH_BIT_LOW: begin
            if (!half_q) begin
              half_d  = 1'b1;
              phase_d = ooksw_pkg::PH_BIT_HIGH;
            end else if (last_bit) begin
              phase_d = ooksw_pkg::PH_END_HIGH;
            end else begin
              pos_d   = pos_q + ooksw_pkg::POS_W'(1);
              half_d  = 1'b0;
              phase_d = ooksw_pkg::PH_BIT_HIGH;
            end
            ticks_d = ooksw_pkg::seg_len(cfg_i.high_time);
            line_d  = 1'b1;
          end
          ooksw_pkg::PH_END_HIGH: begin
            phase_d = ooksw_pkg::PH_END_LOW;
            ticks_d = ooksw_pkg::seg_len(cfg_i.end_low_time);
            line_d  = 1'b0;
          end
          ooksw_pkg::PH_END_LOW: begin
            reps_d = reps_dec;
            if (reps_dec != '0) begin
              phase_d = ooksw_pkg::PH_START_HIGH;
              ticks_d = ooksw_pkg::seg_len(cfg_i.high_time);
              line_d  = 1'b1;
            end else begin
              phase_d = ooksw_pkg::PH_IDLE;
              ticks_d = '0;
              reps_d  = '0;
              line_d  = 1'b0;
            end
          end
          default: begin
            phase_d = ooksw_pkg::PH_IDLE;
            ticks_d = '0;
            reps_d  = '0;
            line_d  = 1'b0;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_q <= '0;
      pos_q   <= '0;
      half_q  <= 1'b0;
      phase_q <= ooksw_pkg::PH_IDLE;
      ticks_q <= '0;
      reps_q  <= '0;
      line_q  <= 1'b0;
    end else if (accept_i) begin
      frame_q <= frame_d;
      pos_q   <= pos_d;
      half_q  <= half_d;
      phase_q <= phase_d;
      ticks_q <= ticks_d;
      reps_q  <= reps_d;
      line_q  <= line_d;
    end
  end

  // A running segment always has ticks and repeats left; idle keeps the line low.
  a_busy_has_ticks : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q != ooksw_pkg::PH_IDLE) |-> (ticks_q != '0))
    else $error("busy segment with no ticks left");

  a_busy_has_repeats : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q != ooksw_pkg::PH_IDLE) |-> (reps_q != '0))
    else $error("busy frame with no repeats left");

  a_idle_line_low : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == ooksw_pkg::PH_IDLE) |-> !line_q)
    else $error("line high while idle");

endmodule

/* design/ooksw_skid.sv */
// ----------------------------------------------------------------------------
// ooksw_skid: two-entry result buffer
// Output register plus skid stage, so a new item is taken while a result waits.
// ----------------------------------------------------------------------------
module ooksw_skid (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  ooksw_pkg::out_item_t push_data_i,
  output logic                 space_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output ooksw_pkg::out_item_t out_data_o
);

  logic                 out_valid_q, out_valid_d;
  logic                 skid_valid_q, skid_valid_d;
  ooksw_pkg::out_item_t out_q, out_d;
  ooksw_pkg::out_item_t skid_q, skid_d;
  logic                 pop;

  assign pop     = out_valid_q && out_ready_i;
  assign space_o = !skid_valid_q;

  always_comb begin
    out_valid_d  = out_valid_q;
    skid_valid_d = skid_valid_q;
    out_d        = out_q;
    skid_d       = skid_q;
    if (skid_valid_q) begin
      if (pop) begin
        out_d        = skid_q;
        skid_valid_d = 1'b0;
      end
    end else if (push_i) begin
      if (!out_valid_q || pop) begin
        out_d       = push_data_i;
        out_valid_d = 1'b1;
      end else begin
        skid_d       = push_data_i;
        skid_valid_d = 1'b1;
      end
    end else if (pop) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // The skid stage is only ever filled behind a waiting output register.
  a_skid_behind_out : assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid entry without output entry");

endmodule
